// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
// Both expect clk_i, and ASSERT_CK also rst_ni, to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- src/acsbm_pkg.sv -----
package acsbm_pkg;

  localparam int ValueW  = 16;
  localparam int CutoffW = 15;
  localparam int MuxW    = 5;

  // Logical channel codes.
  localparam logic [3:0] ChBattCurrent = 4'd0;
  localparam logic [3:0] ChFiveVolts   = 4'd1;
  localparam logic [3:0] ChBattVolts   = 4'd2;
  localparam logic [3:0] ChDieTemp     = 4'd3;

  // Result status codes.
  localparam logic StatusOk          = 1'b0;
  localparam logic StatusUnsupported = 1'b1;

  // Analog mux inputs used by the channels.
  localparam logic [MuxW-1:0] MuxBattCurrent = 5'd13;
  localparam logic [MuxW-1:0] MuxFiveVolts   = 5'd23;
  localparam logic [MuxW-1:0] MuxBattVolts   = 5'd22;
  localparam logic [MuxW-1:0] MuxTempSensor  = 5'd24;
  localparam logic [MuxW-1:0] MuxNone        = 5'd0;

  // Scaling datapath widths: a 17-bit sample times a 27-bit coefficient.
  localparam int SampW = 17;
  localparam int CoefW = 27;
  localparam int ProdW = SampW + CoefW;
  localparam int QuotW = 21;

  // Battery current is 299400/36864 = 12475/1536; it is done as a multiply
  // by ceil(12475 * 2^23 / 1536) and a shift by 23, which is exact for every
  // sample that does not saturate.
  localparam logic [CoefW-1:0] CoefBattCurrent = 27'd68130134;
  localparam logic [CoefW-1:0] CoefFiveVolts   = 27'd5988;
  localparam logic [CoefW-1:0] CoefBattVolts   = 27'd17964;
  localparam logic [CoefW-1:0] CoefDieTemp     = 27'd2246;

  // Largest battery-current sample whose scaled value stays below 32768.
  localparam logic [SampW-1:0] BattCurrentMaxSample = 17'd4034;
  localparam logic [SampW-1:0] RawMax               = 17'd32767;
  localparam logic [QuotW-1:0] PosMax               = 21'd32767;
  // Die temperature is 1475 - q; below -32768 once q exceeds 1475 + 32768.
  localparam logic [QuotW-1:0] TempQuotMax          = 21'd34243;
  localparam int              TempOffset            = 1475;

  localparam logic signed [ValueW-1:0] ValueMax  = 16'sh7fff;
  localparam logic signed [ValueW-1:0] ValueMin  = 16'sh8000;
  localparam logic signed [ValueW-1:0] ValueZero = 16'sh0000;

  typedef struct packed {
    logic                      status;
    logic signed [ValueW-1:0]  value;
    logic [MuxW-1:0]           mux;
    logic                      batt_update;
    logic                      at_or_below;
  } acsbm_result_t;

endpackage

// ----- src/acsbm_scaler.sv -----
module acsbm_scaler #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [3:0]                   channel_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic                         raw_mode_i,
  input  logic [acsbm_pkg::CutoffW-1:0] cutoff_i,
  output acsbm_pkg::acsbm_result_t     res_o
);

  logic [acsbm_pkg::SampW-1:0] samp;
  logic [acsbm_pkg::CoefW-1:0] coef;
  logic [acsbm_pkg::ProdW-1:0] prod;
  logic [acsbm_pkg::QuotW-1:0] quot_hi;
  logic [acsbm_pkg::QuotW-1:0] quot_lo;
  logic [acsbm_pkg::QuotW:0]   temp_diff;
  logic signed [acsbm_pkg::ValueW-1:0] scaled;
  logic signed [acsbm_pkg::ValueW-1:0] raw_val;

  assign samp = acsbm_pkg::SampW'(sample_i);

  always_comb begin
    case (channel_i)
      acsbm_pkg::ChBattCurrent: coef = acsbm_pkg::CoefBattCurrent;
      acsbm_pkg::ChFiveVolts:   coef = acsbm_pkg::CoefFiveVolts;
      acsbm_pkg::ChBattVolts:   coef = acsbm_pkg::CoefBattVolts;
      default:                  coef = acsbm_pkg::CoefDieTemp;
    endcase
  end

  assign prod    = acsbm_pkg::ProdW'(samp) * acsbm_pkg::ProdW'(coef);
  assign quot_hi = prod[23 +: acsbm_pkg::QuotW];
  assign quot_lo = prod[12 +: acsbm_pkg::QuotW];
  // The sensor slope is negative, so the truncated quotient is subtracted.
  assign temp_diff = (acsbm_pkg::QuotW + 1)'(acsbm_pkg::TempOffset) - {1'b0, quot_lo};

  always_comb begin
    case (channel_i)
      acsbm_pkg::ChBattCurrent: begin
        if (samp > acsbm_pkg::BattCurrentMaxSample) begin
          scaled = acsbm_pkg::ValueMax;
        end else begin
          scaled = acsbm_pkg::ValueW'(quot_hi);
        end
      end
      acsbm_pkg::ChDieTemp: begin
        if (quot_lo > acsbm_pkg::TempQuotMax) begin
          scaled = acsbm_pkg::ValueMin;
        end else begin
          scaled = temp_diff[acsbm_pkg::ValueW-1:0];
        end
      end
      default: begin
        if (quot_lo > acsbm_pkg::PosMax) begin
          scaled = acsbm_pkg::ValueMax;
        end else begin
          scaled = acsbm_pkg::ValueW'(quot_lo);
        end
      end
    endcase
  end

  assign raw_val = (samp > acsbm_pkg::RawMax) ? acsbm_pkg::ValueMax
                                              : samp[acsbm_pkg::ValueW-1:0];

  always_comb begin
    res_o.status      = acsbm_pkg::StatusOk;
    res_o.value       = raw_mode_i ? raw_val : scaled;
    res_o.batt_update = 1'b0;
    // Battery volts are never negative, so an unsigned compare is safe.
    res_o.at_or_below = {1'b0, cutoff_i} >= scaled[acsbm_pkg::ValueW-1:0];
    case (channel_i)
      acsbm_pkg::ChBattCurrent: res_o.mux = acsbm_pkg::MuxBattCurrent;
      acsbm_pkg::ChFiveVolts:   res_o.mux = acsbm_pkg::MuxFiveVolts;
      acsbm_pkg::ChBattVolts: begin
        res_o.mux         = acsbm_pkg::MuxBattVolts;
        res_o.batt_update = !raw_mode_i;
      end
      acsbm_pkg::ChDieTemp:     res_o.mux = acsbm_pkg::MuxTempSensor;
      default: begin
        res_o.status = acsbm_pkg::StatusUnsupported;
        res_o.value  = acsbm_pkg::ValueZero;
        res_o.mux    = acsbm_pkg::MuxNone;
      end
    endcase
  end

endmodule

// ----- src/adc_channel_scaler_battery_monitor.sv -----
// Scales one converter sample per item for a logical channel (battery current,
// 5 V rail, battery volts, die temperature) and returns the mux input, status
// and the raw or saturated scaled value. The block takes one item every cycle
// while the output is not stalled. An accepted item loads the input register,
// which feeds the single constant-coefficient multiply and the saturation
// logic; these load the output register when it is free. A stalled result
// holds the output register, and one more item can wait in the input register
// behind it. Scaled battery-volt items are compared with the cutoff register
// to keep the low-battery flag and to mark the low and restored events on the
// result. The cutoff resets to zero and is written through the configuration
// channel, which is always ready; write it only while no item is in flight.
module adc_channel_scaler_battery_monitor #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [acsbm_pkg::CutoffW-1:0] cfg_low_battery_cutoff_mv_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    channel_i,
  input  logic [SAMPLE_BITS-1:0]        raw_sample_i,
  input  logic                          raw_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic signed [acsbm_pkg::ValueW-1:0] value_o,
  output logic [acsbm_pkg::MuxW-1:0]    analog_input_select_o,
  output logic                          battery_low_event_o,
  output logic                          battery_restored_event_o,
  output logic                          battery_low_flag_o
);

  logic [acsbm_pkg::CutoffW-1:0] cutoff_q;
  logic                          in_valid_q, in_valid_d;
  logic [3:0]                    channel_q;
  logic [SAMPLE_BITS-1:0]        sample_q;
  logic                          raw_mode_q;
  logic                          out_valid_q, out_valid_d;
  logic                          batt_low_q, batt_low_d;
  logic                          ev_low_d, ev_rest_d;
  logic                          out_free, advance, accept;
  acsbm_pkg::acsbm_result_t      res;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign advance     = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign accept      = in_valid_i && in_ready_o;

  acsbm_scaler #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scaler (
    .channel_i  (channel_q),
    .sample_i   (sample_q),
    .raw_mode_i (raw_mode_q),
    .cutoff_i   (cutoff_q),
    .res_o      (res)
  );

  always_comb begin
    batt_low_d = batt_low_q;
    ev_low_d   = 1'b0;
    ev_rest_d  = 1'b0;
    if (res.batt_update) begin
      if (batt_low_q && !res.at_or_below) begin
        batt_low_d = 1'b0;
        ev_rest_d  = 1'b1;
      end else if (!batt_low_q && res.at_or_below) begin
        batt_low_d = 1'b1;
        ev_low_d   = 1'b1;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (out_free) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q    <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      batt_low_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cutoff_q <= cfg_low_battery_cutoff_mv_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        batt_low_q <= batt_low_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      channel_q  <= channel_i;
      sample_q   <= raw_sample_i;
      raw_mode_q <= raw_mode_i;
    end
    if (advance) begin
      status_o                 <= res.status;
      value_o                  <= res.value;
      analog_input_select_o    <= res.mux;
      battery_low_event_o      <= ev_low_d;
      battery_restored_event_o <= ev_rest_d;
      battery_low_flag_o       <= batt_low_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/acsbm_checker.sv -----
`include "assert_macros.svh"

module acsbm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          status_o,
  input logic signed [acsbm_pkg::ValueW-1:0] value_o,
  input logic [acsbm_pkg::MuxW-1:0]    analog_input_select_o,
  input logic                          battery_low_event_o,
  input logic                          battery_restored_event_o,
  input logic                          battery_low_flag_o
);

  logic both_events, event_ok, unsup_item, unsup_clear, ok_item, mux_known, stalled;

  assign both_events = battery_low_event_o && battery_restored_event_o;
  assign event_ok    = (!battery_low_event_o || battery_low_flag_o) &&
                       (!battery_restored_event_o || !battery_low_flag_o);
  assign unsup_item  = out_valid_o && status_o == acsbm_pkg::StatusUnsupported;
  assign unsup_clear = value_o == acsbm_pkg::ValueZero &&
                       analog_input_select_o == acsbm_pkg::MuxNone &&
                       !battery_low_event_o && !battery_restored_event_o;
  assign ok_item     = out_valid_o && status_o == acsbm_pkg::StatusOk;
  assign mux_known   = analog_input_select_o == acsbm_pkg::MuxBattCurrent ||
                       analog_input_select_o == acsbm_pkg::MuxFiveVolts ||
                       analog_input_select_o == acsbm_pkg::MuxBattVolts ||
                       analog_input_select_o == acsbm_pkg::MuxTempSensor;
  assign stalled     = out_valid_o && !out_ready_i;

  // An item cannot both lower and restore the battery state.
  `ASSERT_CK(a_events_excl, out_valid_o |-> !both_events, "both battery events set")

  // An event must agree with the flag that the same item reports.
  `ASSERT_CK(a_event_flag, out_valid_o |-> event_ok, "battery event disagrees with flag")

  // Unsupported channels give a zero value, no mux input and no events.
  `ASSERT_CK(a_unsupported, unsup_item |-> unsup_clear, "unsupported item not cleared")

  // Supported channels always name one of the four mux inputs.
  `ASSERT_CK(a_mux_known, ok_item |-> mux_known, "unexpected mux input")

  // A stalled result item holds.
  `ASSERT_CK(a_out_hold, stalled |=> (out_valid_o && $stable(value_o) && $stable(status_o)), "stalled result item changed")

endmodule

bind adc_channel_scaler_battery_monitor acsbm_checker u_acsbm_checker (.*);
